### src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/lcdns_pkg.sv
package lcdns_pkg;

    localparam int STEP_W      = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    typedef enum logic [1:0] {
        MODE_CHAR  = 2'd0,
        MODE_POS   = 2'd1,
        MODE_INIT  = 2'd2,
        MODE_FLAGS = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_FSET   = 2'd0,
        REG_IFLAGS = 2'd1,
        REG_LBASE  = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_idx;

    localparam logic [4:0] FSET_RESET   = 5'd8;
    localparam logic [2:0] IFLAGS_RESET = 3'd4;
    localparam logic [6:0] LBASE_RESET  = 7'd64;

    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;
    localparam logic [7:0] CMD_DISPLAY  = 8'h08;
    localparam logic [7:0] CMD_FUNCTION = 8'h20;
    localparam logic [7:0] CMD_ADDRESS  = 8'h80;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_FF = 8'h0C;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam logic [3:0] NIB_WAKE   = 4'h3;
    localparam logic [3:0] NIB_4BIT   = 4'h2;
    localparam logic [3:0] SLOW_MS    = 4'd5;
    localparam logic [3:0] POWERUP_MS = 4'd15;

    // init sequence steps
    localparam logic [STEP_W-1:0] STEP_WAKE_LAST = 4'd2;
    localparam logic [STEP_W-1:0] STEP_4BIT      = 4'd3;
    localparam logic [STEP_W-1:0] STEP_CLEAR_LO  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_INIT_LAST = 4'd11;
    localparam logic [2:0]        PAIR_FSET      = 3'd2;
    localparam logic [2:0]        PAIR_DISPLAY   = 3'd3;
    localparam logic [2:0]        PAIR_CLEAR     = 3'd4;

    typedef struct packed {
        logic       is_init;
        logic [7:0] cmd_byte;
        logic       rs;
        logic       slow;
        logic [4:0] fset;
        logic [2:0] dflags;
    } t_cmd;

    typedef struct packed {
        logic [3:0] nibble;
        logic       rs;
        logic [3:0] pre_wait;
        logic [3:0] after;
        logic       last;
    } t_strobe;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic t_strobe strobe_of(t_cmd c, logic [STEP_W-1:0] step);
        t_strobe    s;
        logic [7:0] b;
        s = '0;
        b = CMD_ENTRY;
        if (!c.is_init) begin
            b        = c.cmd_byte;
            s.rs     = c.rs;
            s.nibble = step[0] ? b[3:0] : b[7:4];
            s.after  = (step[0] && c.slow) ? SLOW_MS : 4'd0;
            s.last   = step[0];
        end else if (step <= STEP_WAKE_LAST) begin
            s.nibble   = NIB_WAKE;
            s.pre_wait = (step == '0) ? POWERUP_MS : 4'd0;
            s.after    = SLOW_MS;
        end else if (step == STEP_4BIT) begin
            s.nibble = NIB_4BIT;
        end else begin
            // two strobes per command byte from step four on
            case (step[3:1])
                PAIR_FSET:    b = CMD_FUNCTION | {3'b000, c.fset};
                PAIR_DISPLAY: b = CMD_DISPLAY | {5'b00000, c.dflags};
                PAIR_CLEAR:   b = CMD_CLEAR;
                default:      b = CMD_ENTRY;
            endcase
            s.nibble = step[0] ? b[3:0] : b[7:4];
            s.after  = (step == STEP_CLEAR_LO) ? SLOW_MS : 4'd0;
            s.last   = (step == STEP_INIT_LAST);
        end
        return s;
    endfunction

endpackage

### src/lcdns_front.sv
module lcdns_front
    import lcdns_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    input  logic              i_in_valid,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_char_code,
    input  logic [6:0]        i_column,
    input  logic              i_row,
    input  logic [2:0]        i_flag_mask,
    input  logic [2:0]        i_flag_values,
    input  t_q_status         i_q_status,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [4:0] r_fset;
    logic [2:0] r_iflags;
    logic [6:0] r_lbase;
    logic [2:0] r_dflags, n_dflags;
    logic       wr_en;
    t_reg_idx   reg_idx;
    logic [6:0] pos_addr;
    logic [2:0] new_flags;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fset   <= FSET_RESET;
            r_iflags <= IFLAGS_RESET;
            r_lbase  <= LBASE_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FSET:   r_fset   <= pwdata[4:0];
                REG_IFLAGS: r_iflags <= pwdata[2:0];
                REG_LBASE:  r_lbase  <= pwdata[6:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FSET:   prdata = {27'd0, r_fset};
            REG_IFLAGS: prdata = {29'd0, r_iflags};
            REG_LBASE:  prdata = {25'd0, r_lbase};
            default:    prdata = '0;
        endcase
    end

    assign o_push    = i_in_valid && !i_q_status.full;
    assign pos_addr  = (i_row ? r_lbase : 7'd0) + i_column;
    assign new_flags = (r_dflags & ~i_flag_mask) | (i_flag_values & i_flag_mask);

    always_comb begin
        o_cmd          = '0;
        o_cmd.fset     = r_fset;
        o_cmd.dflags   = r_iflags;
        n_dflags       = r_dflags;
        unique case (t_mode'(i_mode))
            MODE_CHAR: begin
                if (i_char_code == CHAR_FF) begin
                    o_cmd.cmd_byte = CMD_CLEAR;
                    o_cmd.slow     = 1'b1;
                end else if (i_char_code == CHAR_LF || i_char_code == CHAR_CR) begin
                    o_cmd.cmd_byte = CMD_ADDRESS | {1'b0, r_lbase};
                end else begin
                    o_cmd.cmd_byte = i_char_code;
                    o_cmd.rs       = 1'b1;
                end
            end
            MODE_POS: begin
                o_cmd.cmd_byte = CMD_ADDRESS | {1'b0, pos_addr};
            end
            MODE_INIT: begin
                o_cmd.is_init = 1'b1;
                n_dflags      = r_iflags;
            end
            MODE_FLAGS: begin
                o_cmd.cmd_byte = CMD_DISPLAY | {5'b00000, new_flags};
                n_dflags       = new_flags;
            end
        endcase
    end

    // flags follow request order, so track them at acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflags <= '0;
        end else if (o_push) begin
            r_dflags <= n_dflags;
        end
    end

endmodule

### src/lcdns_queue.sv
module lcdns_queue
    import lcdns_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/lcdns_back.sv
module lcdns_back
    import lcdns_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_head,
    input  t_q_status i_q_status,
    output logic      o_pop,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_strobe   o_strobe
);

    t_cmd              r_cur;
    logic              r_cur_vld;
    logic [STEP_W-1:0] r_step;
    t_strobe           r_out;
    logic              r_out_vld;
    t_strobe           cur_s;
    logic              out_free, adv, cur_done;

    assign cur_s    = strobe_of(r_cur, r_step);
    assign out_free = !r_out_vld || !i_out_stall;
    assign adv      = r_cur_vld && out_free;
    assign cur_done = adv && cur_s.last;
    // take the next command as the current one issues its final word
    assign o_pop    = !i_q_status.empty && (!r_cur_vld || cur_done);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
        if (adv) begin
            r_out <= cur_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= 1'b0;
            r_step    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cur_vld <= 1'b1;
                r_step    <= '0;
            end else begin
                if (cur_done) begin
                    r_cur_vld <= 1'b0;
                end
                if (adv) begin
                    r_step <= r_step + 1'b1;
                end
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_strobe    = r_out;

endmodule

### src/char_lcd_nibble_sequencer.sv
// 4-bit character LCD strobe sequencer.
// Input channel (i_in_valid / o_in_stall): one request word per accepted
// cycle: a character, a cursor position, the init sequence or a flag update.
// Output channel (o_out_valid / i_out_stall): one word per enable strobe,
// with nibble, register select, waits in ms and a last mark on the final
// strobe of each request.
// Character, position and flag requests give two strobes, init gives twelve.
// An accepted request is registered in the command queue, then in the
// current-command register, before its first strobe reaches the output word.
// The strobe generator issues one word per cycle unless a held output word
// stalls it, and takes the next command as the current one issues its last.
// A two-entry command queue sits between request decode and the strobe
// generator; o_in_stall rises only when that queue is full.
// While a valid output word meets i_out_stall, it holds and the generator waits.
// Reset empties the queue, drops any pending strobe, clears the display
// flags and loads the register reset values. The APB port is always ready.
module char_lcd_nibble_sequencer
    import lcdns_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_char_code,
    input  logic [6:0]        i_column,
    input  logic              i_row,
    input  logic [2:0]        i_flag_mask,
    input  logic [2:0]        i_flag_values,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [3:0]        o_nibble,
    output logic              o_register_select,
    output logic [3:0]        o_wait_before_ms,
    output logic [3:0]        o_wait_after_ms,
    output logic              o_last
);

`include "assert_macros.svh"

    t_q_status q_status;
    t_cmd      push_cmd, head_cmd;
    logic      push, pop;
    t_strobe   strobe;

    assign pready     = 1'b1;
    assign o_in_stall = q_status.full;

    lcdns_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .i_in_valid    (i_in_valid),
        .i_mode        (i_mode),
        .i_char_code   (i_char_code),
        .i_column      (i_column),
        .i_row         (i_row),
        .i_flag_mask   (i_flag_mask),
        .i_flag_values (i_flag_values),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    lcdns_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    lcdns_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_cmd),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_strobe    (strobe)
    );

    assign o_nibble          = strobe.nibble;
    assign o_register_select = strobe.rs;
    assign o_wait_before_ms  = strobe.pre_wait;
    assign o_wait_after_ms   = strobe.after;
    assign o_last            = strobe.last;

    `ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, push, !q_status.empty)
    `ASSERT_SAME(a_pop_nonempty, i_clk, i_rst_n, pop, !q_status.empty)
    `ASSERT_SAME(a_powerup_wake, i_clk, i_rst_n,
        o_out_valid && o_wait_before_ms != 4'd0,
        o_nibble == NIB_WAKE && !o_register_select && !o_last)
    `ASSERT_SAME(a_data_no_wait, i_clk, i_rst_n,
        o_out_valid && o_register_select,
        o_wait_before_ms == 4'd0 && o_wait_after_ms == 4'd0)

endmodule

### verif/lcd_strobe_checker.sv
`timescale 1ns / 100ps
module lcd_strobe_checker
    import lcdns_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    input  logic              i_pready,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_char_code,
    input  logic [6:0]        i_column,
    input  logic              i_row,
    input  logic [2:0]        i_flag_mask,
    input  logic [2:0]        i_flag_values,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [3:0]        i_nibble,
    input  logic              i_register_select,
    input  logic [3:0]        i_wait_before_ms,
    input  logic [3:0]        i_wait_after_ms,
    input  logic              i_last,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int MAX_PRINTS = 30;

    t_strobe    strobes_due[$];
    logic [4:0] fset_bits;
    logic [2:0] init_flags;
    logic [6:0] line_base;
    logic [2:0] disp_flags;
    int         strobes_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        strobes_seen = 0;
    end

    task automatic report_mismatch(input string msg);
        if (o_fail_count < MAX_PRINTS)
            $display("MISMATCH at %0t, strobe %0d: %s", $realtime, strobes_seen, msg);
        o_fail_count++;
    endtask

    function void push_strobe(logic [3:0] nib, logic rs, logic [3:0] wb, logic [3:0] wa);
        t_strobe s;
        s.nibble   = nib;
        s.rs       = rs;
        s.pre_wait = wb;
        s.after    = wa;
        s.last     = 1'b0;
        strobes_due.push_back(s);
    endfunction

    // high nibble first, one register select for both halves
    function void push_byte(logic [7:0] b, logic rs, logic [3:0] wa);
        push_strobe(b[7:4], rs, 4'd0, 4'd0);
        push_strobe(b[3:0], rs, 4'd0, wa);
    endfunction

    function void predict_strobes(logic [1:0] mode, logic [7:0] ch, logic [6:0] col,
                                  logic row, logic [2:0] mask, logic [2:0] vals);
        t_strobe    tail;
        logic [6:0] addr;
        case (t_mode'(mode))
            MODE_CHAR: begin
                if (ch == CHAR_FF)
                    push_byte(CMD_CLEAR, 1'b0, SLOW_MS);
                else if (ch == CHAR_LF || ch == CHAR_CR)
                    push_byte(CMD_ADDRESS | {1'b0, line_base}, 1'b0, 4'd0);
                else
                    push_byte(ch, 1'b1, 4'd0);
            end
            MODE_POS: begin
                // 7-bit sum wraps the address
                addr = (row ? line_base : 7'd0) + col;
                push_byte(CMD_ADDRESS | {1'b0, addr}, 1'b0, 4'd0);
            end
            MODE_INIT: begin
                for (int i = 0; i < 3; i++)
                    push_strobe(NIB_WAKE, 1'b0, (i == 0) ? POWERUP_MS : 4'd0, SLOW_MS);
                push_strobe(NIB_4BIT, 1'b0, 4'd0, 4'd0);
                push_byte(CMD_FUNCTION | {3'b000, fset_bits}, 1'b0, 4'd0);
                disp_flags = init_flags;
                push_byte(CMD_DISPLAY | {5'b00000, disp_flags}, 1'b0, 4'd0);
                push_byte(CMD_CLEAR, 1'b0, SLOW_MS);
                push_byte(CMD_ENTRY, 1'b0, 4'd0);
            end
            default: begin
                disp_flags = (disp_flags & ~mask) | (vals & mask);
                push_byte(CMD_DISPLAY | {5'b00000, disp_flags}, 1'b0, 4'd0);
            end
        endcase
        tail = strobes_due.pop_back();
        tail.last = 1'b1;
        strobes_due.push_back(tail);
    endfunction

    always @(posedge i_clk) begin
        t_strobe want;
        if (!i_rst_n) begin
            strobes_due.delete();
            fset_bits  = FSET_RESET;
            init_flags = IFLAGS_RESET;
            line_base  = LBASE_RESET;
            disp_flags = 3'd0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_FSET:   fset_bits  = i_pwdata[4:0];
                    REG_IFLAGS: init_flags = i_pwdata[2:0];
                    REG_LBASE:  line_base  = i_pwdata[6:0];
                    default:    ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (strobes_due.size() == 0) begin
                    report_mismatch("strobe word with no request pending");
                end else begin
                    want = strobes_due.pop_front();
                    if (i_nibble !== want.nibble)
                        report_mismatch($sformatf("nibble %h, expected %h",
                                                  i_nibble, want.nibble));
                    if (i_register_select !== want.rs)
                        report_mismatch($sformatf("register_select %b, expected %b",
                                                  i_register_select, want.rs));
                    if (i_wait_before_ms !== want.pre_wait)
                        report_mismatch($sformatf("wait_before_ms %0d, expected %0d",
                                                  i_wait_before_ms, want.pre_wait));
                    if (i_wait_after_ms !== want.after)
                        report_mismatch($sformatf("wait_after_ms %0d, expected %0d",
                                                  i_wait_after_ms, want.after));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  i_last, want.last));
                end
                strobes_seen++;
            end
            if (i_in_valid && !i_in_stall)
                predict_strobes(i_mode, i_char_code, i_column, i_row,
                                i_flag_mask, i_flag_values);
        end
        o_pending = strobes_due.size();
    end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
module tb;
    import lcdns_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 62;
    localparam int HOLD_CYCLES     = 80;
    localparam int DRAIN_CYCLES    = 8;
    localparam int END_CYCLES      = 20;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_in_valid    = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_mode        = '0;
    logic [7:0]        i_char_code   = '0;
    logic [6:0]        i_column      = '0;
    logic              i_row         = 1'b0;
    logic [2:0]        i_flag_mask   = '0;
    logic [2:0]        i_flag_values = '0;
    logic              o_out_valid;
    logic              i_out_stall   = 1'b0;
    logic [3:0]        o_nibble;
    logic              o_register_select;
    logic [3:0]        o_wait_before_ms;
    logic [3:0]        o_wait_after_ms;
    logic              o_last;

    int   fail_count;
    int   pending;
    int   cycles     = 0;
    int   idle_pct   = 0;
    int   stall_pct  = 0;
    logic hold_tgl   = 1'b0;
    logic hold_seen  = 1'b0;
    int   hold_left  = 0;

    char_lcd_nibble_sequencer u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_char_code       (i_char_code),
        .i_column          (i_column),
        .i_row             (i_row),
        .i_flag_mask       (i_flag_mask),
        .i_flag_values     (i_flag_values),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_nibble          (o_nibble),
        .o_register_select (o_register_select),
        .o_wait_before_ms  (o_wait_before_ms),
        .o_wait_after_ms   (o_wait_after_ms),
        .o_last            (o_last)
    );

    lcd_strobe_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .i_pready          (pready),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_char_code       (i_char_code),
        .i_column          (i_column),
        .i_row             (i_row),
        .i_flag_mask       (i_flag_mask),
        .i_flag_values     (i_flag_values),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_nibble          (o_nibble),
        .i_register_select (o_register_select),
        .i_wait_before_ms  (o_wait_before_ms),
        .i_wait_after_ms   (o_wait_after_ms),
        .i_last            (o_last),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // display side: random stalls, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_tgl != hold_seen) begin
            hold_seen   <= hold_tgl;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_req(input t_mode m, input logic [7:0] ch, input logic [6:0] col,
                            input logic r, input logic [2:0] mk, input logic [2:0] vl);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= m;
        i_char_code   <= ch;
        i_column      <= col;
        i_row         <= r;
        i_flag_mask   <= mk;
        i_flag_values <= vl;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_req(MODE_CHAR, ch, 7'($urandom), 1'($urandom), 3'($urandom), 3'($urandom));
    endtask

    task automatic send_pos(input logic r, input logic [6:0] col);
        send_req(MODE_POS, 8'($urandom), col, r, 3'($urandom), 3'($urandom));
    endtask

    task automatic send_flags(input logic [2:0] mk, input logic [2:0] vl);
        send_req(MODE_FLAGS, 8'($urandom), 7'($urandom), 1'($urandom), mk, vl);
    endtask

    task automatic send_random();
        int         pick;
        t_mode      m;
        logic [7:0] ch;
        pick = $urandom_range(99);
        if (pick < 10)
            m = MODE_INIT;
        else if (pick < 50)
            m = MODE_CHAR;
        else if (pick < 75)
            m = MODE_POS;
        else
            m = MODE_FLAGS;
        // bias toward the control characters
        pick = $urandom_range(9);
        if (pick == 0)
            ch = CHAR_FF;
        else if (pick == 1)
            ch = CHAR_LF;
        else if (pick == 2)
            ch = CHAR_CR;
        else
            ch = 8'($urandom);
        send_req(m, ch, 7'($urandom), 1'($urandom), 3'($urandom), 3'($urandom));
    endtask

    // leaves psel high; the caller drops it after the last write
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [4:0] fset, input logic [2:0] iflags,
                               input logic [6:0] lbase);
        write_reg(REG_FSET, {27'($urandom), fset});
        write_reg(REG_IFLAGS, {29'($urandom), iflags});
        write_reg(REG_LBASE, {25'($urandom), lbase});
        write_reg(REG_NONE, $urandom);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid, then wait until every predicted strobe has come out
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_flags(3'b000, 3'b111);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CHAR_FF);
        send_char(CHAR_LF);
        send_char(CHAR_CR);
        send_char(8'h0B);
        send_char(8'h0E);
        send_char(8'h41);
        send_pos(1'b0, 7'd0);
        send_pos(1'b1, 7'd0);
        send_pos(1'b0, 7'd127);
        send_pos(1'b1, 7'd127);
        send_pos(1'b1, 7'd63);
        send_req(MODE_INIT, 8'($urandom), 7'($urandom), 1'($urandom), 3'b111, 3'b111);
        send_flags(3'b111, 3'b000);
        send_flags(3'b111, 3'b111);
        send_flags(3'b100, 3'b000);
        send_flags(3'b010, 3'b101);
        send_flags(3'b001, 3'b110);
        send_flags(3'b000, 3'b000);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drain();
            if (ph == 1)
                load_config(5'd31, 3'd7, 7'd127);
            else if (ph == 2)
                load_config(5'd0, 3'd0, 7'd0);
            else if (ph > 2)
                load_config(5'($urandom), 3'($urandom), 7'($urandom));
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            // hold the display side off so the request queue fills
            if (ph == 0)
                hold_tgl <= ~hold_tgl;
            repeat (ITEMS_PER_PHASE) send_random();
        end

        wait_drain();
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/lcdns_pkg.sv
src/lcdns_front.sv
src/lcdns_queue.sv
src/lcdns_back.sv
src/char_lcd_nibble_sequencer.sv
verif/lcd_strobe_checker.sv
verif/tb.sv
